// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the sieve RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, cond, nxt) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, cond, nxt)
`endif
`endif

// ===== sv/lsm_pkg.sv =====
// ----------------------------------------------------------------------------
// Sieve package
// Sizes and codes shared by the Mobius sieve files.
// ----------------------------------------------------------------------------
`default_nettype none
package lsm_pkg;
  localparam int MaxNumber = 65536;
  localparam int MaxPrimes = 8192;
  localparam int NumW = 17;
  localparam int AddrW = $clog2(MaxNumber + 1);
  localparam int PidxW = $clog2(MaxPrimes);
  localparam int PcntW = $clog2(MaxPrimes + 1);
  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StOrder = 2'd1;
  localparam logic [1:0] StLimit = 2'd2;
endpackage
`default_nettype wire

// ===== sv/lsm_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module lsm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== sv/lsm_div.sv =====
// ----------------------------------------------------------------------------
// Remainder unit
// Restoring division, one quotient bit per cycle; reports n mod p == 0.
// ----------------------------------------------------------------------------
`default_nettype none
module lsm_div (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [lsm_pkg::NumW-1:0] dividend,
  input  wire logic [lsm_pkg::NumW-1:0] divisor,
  output logic                          done,
  output logic                          zero_rem
);
  localparam int CntW = $clog2(lsm_pkg::NumW + 1);
  logic [lsm_pkg::NumW-1:0] q_r, d_r;
  logic [lsm_pkg::NumW:0]   rem_r, trial;
  logic [CntW-1:0]          cnt_r;
  logic                     busy_r;
  assign trial = {rem_r[lsm_pkg::NumW-1:0], q_r[lsm_pkg::NumW-1]} - {1'b0, d_r};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        q_r    <= dividend;
        d_r    <= divisor;
        rem_r  <= '0;
        cnt_r  <= CntW'(lsm_pkg::NumW);
      end else if (busy_r) begin
        if (!trial[lsm_pkg::NumW])
          rem_r <= trial;
        else
          rem_r <= {rem_r[lsm_pkg::NumW-1:0], q_r[lsm_pkg::NumW-1]};
        q_r   <= q_r << 1;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CntW'(1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end
  assign zero_rem = (rem_r == '0);
endmodule
`default_nettype wire

// ===== sv/linear_sieve_mobius.sv =====
// ----------------------------------------------------------------------------
// Linear sieve Mobius unit: one number per transaction, results kept in order.
// Sequential: a rejected number or number one is answered straight from idle;
// otherwise the unit walks the prime list up to the smallest factor, dividing.
// Reset: synchronous, active low; a composite clearing pass follows.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module linear_sieve_mobius (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [16:0] number
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [1:0] mu_value, [2] is_prime, [4:3] status
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [16:0] cfg_data
);
  localparam int NW = lsm_pkg::NumW;
  localparam int AW = lsm_pkg::AddrW;
  localparam int PW = lsm_pkg::PidxW;
  localparam int CW = lsm_pkg::PcntW;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RDN, S_GETN, S_RDP, S_GETP, S_DIV, S_WAIT, S_OUT
  } state_t;
  state_t state_r;

  logic [NW-1:0] lim_r, n_r, exp_r, p_r;
  logic [CW-1:0] pcnt_r, pi_r;
  logic [AW-1:0] clr_r;
  logic [1:0]    mu_r;
  logic          prime_r;
  logic [2*NW-1:0] prod_r;
  logic [7:0]    out_r;
  logic          outv_r;

  // memory ports
  logic          cm_we, mu_we, pl_we;
  logic [AW-1:0] cm_wa, mu_wa, cm_ra;
  logic          cm_wd, cm_rd;
  logic [1:0]    mu_wd, mu_rd;
  logic [PW-1:0] pl_wa, pl_ra;
  logic [NW-1:0] pl_wd, pl_rd;
  logic          div_start, div_done, div_zero;

  lsm_ram #(.Width(1), .Depth(1 << AW)) u_comp (
    .clk, .we(cm_we), .waddr(cm_wa), .wdata(cm_wd), .raddr(cm_ra), .rdata(cm_rd));
  lsm_ram #(.Width(2), .Depth(1 << AW)) u_mu (
    .clk, .we(mu_we), .waddr(mu_wa), .wdata(mu_wd), .raddr(cm_ra), .rdata(mu_rd));
  lsm_ram #(.Width(NW), .Depth(lsm_pkg::MaxPrimes)) u_pl (
    .clk, .we(pl_we), .waddr(pl_wa), .wdata(pl_wd), .raddr(pl_ra), .rdata(pl_rd));
  lsm_div u_div (.clk, .rst_n, .start(div_start), .dividend(n_r), .divisor(p_r),
    .done(div_done), .zero_rem(div_zero));

  logic [NW-1:0] eff_lim, in_num;
  assign eff_lim = (lim_r > NW'(lsm_pkg::MaxNumber)) ? NW'(lsm_pkg::MaxNumber) : lim_r;
  assign in_num  = in_tdata[NW-1:0];
  assign in_tready = (state_r == S_IDLE) && !outv_r;
  assign cfg_ready = 1'b1;
  assign out_tvalid = outv_r;
  assign out_tdata  = out_r;
  assign cm_ra = n_r[AW-1:0];
  assign pl_ra = pi_r[PW-1:0];
  assign div_start = (state_r == S_DIV);

  always_comb begin
    cm_we = 1'b0; cm_wa = prod_r[AW-1:0]; cm_wd = 1'b1;
    mu_we = 1'b0; mu_wa = prod_r[AW-1:0]; mu_wd = 2'b00;
    pl_we = 1'b0; pl_wa = pcnt_r[PW-1:0]; pl_wd = n_r;
    case (state_r)
      S_CLEAR: begin cm_we = 1'b1; cm_wa = clr_r; cm_wd = 1'b0; end
      S_GETN: pl_we = !cm_rd && (pcnt_r != CW'(lsm_pkg::MaxPrimes));
      S_WAIT: if (div_done) begin
        cm_we = 1'b1; mu_we = 1'b1; mu_wd = div_zero ? 2'b00 : -mu_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; clr_r <= '0; lim_r <= NW'(lsm_pkg::MaxNumber); exp_r <= NW'(1);
      pcnt_r <= '0; outv_r <= 1'b0;
    end else begin
      if (cfg_valid) lim_r <= cfg_data;
      if (outv_r && out_tready) outv_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == AW'(lsm_pkg::MaxNumber)) state_r <= S_IDLE;
        end
        S_IDLE: if (in_tvalid && in_tready) begin
          n_r <= in_num;
          if (in_num != exp_r) begin
            out_r <= {3'b0, lsm_pkg::StOrder, 3'b000}; outv_r <= 1'b1;
          end else if (in_num > eff_lim) begin
            out_r <= {3'b0, lsm_pkg::StLimit, 3'b000}; outv_r <= 1'b1;
          end else if (in_num == NW'(1)) begin
            exp_r <= NW'(2);
            out_r <= {3'b0, lsm_pkg::StOk, 3'b001}; outv_r <= 1'b1;
          end else state_r <= S_RDN;
        end
        S_RDN: state_r <= S_GETN;
        S_GETN: begin
          prime_r <= !cm_rd; pi_r <= '0;
          if (!cm_rd && pcnt_r == CW'(lsm_pkg::MaxPrimes)) begin
            out_r <= {3'b0, lsm_pkg::StLimit, 3'b000}; outv_r <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            mu_r <= cm_rd ? mu_rd : 2'b11;
            if (!cm_rd) pcnt_r <= pcnt_r + 1'b1;
            state_r <= S_RDP;
          end
        end
        S_RDP: state_r <= (pi_r < pcnt_r) ? S_GETP : S_OUT;
        S_GETP: begin
          p_r <= pl_rd;
          prod_r <= n_r * pl_rd;
          state_r <= S_DIV;
        end
        S_DIV: state_r <= (p_r == '0 || prod_r > (2*NW)'(eff_lim)) ? S_OUT : S_WAIT;
        S_WAIT: if (div_done) begin
          pi_r <= pi_r + 1'b1;
          state_r <= div_zero ? S_OUT : S_RDP;
        end
        S_OUT: begin
          exp_r <= n_r + 1'b1;
          out_r <= {3'b0, lsm_pkg::StOk, prime_r, mu_r}; outv_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `ASSERT_NEXT(a_out_hold, clk, rst_n, outv_r && !out_tready, outv_r && $stable(out_r))
  `ASSERT_IMPL(a_no_acc_clear, clk, rst_n, (state_r == S_CLEAR) |-> !in_tready)
  `ASSERT_IMPL(a_pcnt_cap, clk, rst_n, pcnt_r <= CW'(lsm_pkg::MaxPrimes))
endmodule
`default_nettype wire

// ===== tb/sv/linear_sieve_mobius_checker.sv =====
// ----------------------------------------------------------------------------
// Mobius sieve checker
// Watches the input, result and configuration channels of the sieve, keeps
// its own sieve state to predict each result and compares field by field.
// ----------------------------------------------------------------------------
`default_nettype none
module linear_sieve_mobius_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [23:0] in_tdata,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [7:0]  out_tdata,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [16:0] cfg_data,
  output int               fail_count,
  output int               pending
);
  typedef struct packed {
    logic [1:0] mu_value;
    logic       is_prime;
    logic [1:0] status;
  } mobius_result_t;

  logic [1:0]     mu_table [0:lsm_pkg::MaxNumber];
  bit             composite [0:lsm_pkg::MaxNumber];
  int unsigned    prime_table [$];
  int unsigned    next_number = 1;
  int unsigned    sieve_limit = 65536;
  mobius_result_t mobius_queue [$];

  function automatic mobius_result_t classify_number(int unsigned n);
    mobius_result_t r;
    int unsigned    lim;
    longint         prod;
    logic [1:0]     mu;
    bit             prime;
    r   = '{mu_value: 2'b00, is_prime: 1'b0, status: lsm_pkg::StOk};
    lim = (sieve_limit > lsm_pkg::MaxNumber) ? lsm_pkg::MaxNumber : sieve_limit;
    if (n != next_number) begin
      r.status = lsm_pkg::StOrder;
      return r;
    end
    if (n > lim) begin
      r.status = lsm_pkg::StLimit;
      return r;
    end
    if (n == 1) begin
      mu_table[1] = 2'b01;
      next_number = 2;
      r.mu_value  = 2'b01;
      return r;
    end
    prime = !composite[n];
    if (prime) begin
      if (prime_table.size() >= lsm_pkg::MaxPrimes) begin
        r.status = lsm_pkg::StLimit;
        return r;
      end
      prime_table.insert(prime_table.size(), n);
      mu_table[n] = 2'b11;
    end
    mu = mu_table[n];
    foreach (prime_table[i]) begin
      prod = longint'(n) * prime_table[i];
      if (prod > lim) break;
      composite[prod] = 1'b1;
      if (n % prime_table[i] == 0) begin
        mu_table[prod] = 2'b00;
        break;
      end
      mu_table[prod] = -mu;
    end
    next_number = n + 1;
    r.mu_value  = mu;
    r.is_prime  = prime;
    return r;
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    mobius_result_t want, got;
    if (rst_n) begin
      // Users must send configuration only while idle; the sieve does not check.
      if (cfg_valid && cfg_ready) sieve_limit = cfg_data;
      if (in_tvalid && in_tready)
        mobius_queue.insert(mobius_queue.size(), classify_number(in_tdata[16:0]));
      if (out_tvalid && out_tready) begin
        got = '{mu_value: out_tdata[1:0], is_prime: out_tdata[2], status: out_tdata[4:3]};
        if (mobius_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result transaction %h", out_tdata);
        end else begin
          want = mobius_queue.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: mu %b/%b prime %b/%b status %b/%b (expected/actual)",
                       want.mu_value, got.mu_value, want.is_prime, got.is_prime,
                       want.status, got.status);
          end
        end
      end
      pending = mobius_queue.size();
    end
  end
endmodule
`default_nettype wire

// ===== tb/sv/linear_sieve_mobius_test.sv =====
// ----------------------------------------------------------------------------
// Mobius sieve testbench
// Drives number streams with gaps and stalls through several limit settings;
// the checker predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
`default_nettype none
module linear_sieve_mobius_test;
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;     // [16:0] number
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;         // [1:0] mu_value, [2] is_prime, [4:3] status
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [16:0] cfg_data = '0;
  int          fail_count;
  int          pending;

  bit          quiet = 0;         // last part of the run: no idling on either side
  bit          hold_request = 0;  // ask the receiver for one long hold-off
  int unsigned next_number = 1;   // stimulus-side view of the sieve position
  int unsigned limit_now = 65536;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  linear_sieve_mobius uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  linear_sieve_mobius_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  // Receiver: bursts of acceptance and stalls, plus one long hold-off on request.
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_request = 0;
      end else if (quiet || $urandom_range(0, 2) != 0) begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end else begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
    end
  end

  // Offer one number and hold it until accepted; sometimes idle first.
  task automatic send_number(int unsigned n);
    int unsigned lim;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, n[16:0]};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // Advance the stream position only for an in-order number within the limit.
    lim = (limit_now > 65536) ? 65536 : limit_now;
    if (n == next_number && n <= lim) next_number++;
  endtask

  // Drain every expected result, let the block settle, then write the limit.
  task automatic write_limit(int unsigned value);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value[16:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    limit_now = value;
  endtask

  // Mostly the next number in order; the rest is junk around and far from it.
  task automatic random_numbers(int count);
    int unsigned r;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 85) send_number(next_number);
      else if (r < 92) send_number($urandom_range(0, 131071));
      else if (r < 96) send_number(next_number + 1);
      else send_number(next_number - 1);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Lowest limit: out-of-order values at both extremes, number one, above limit.
    write_limit(1);
    send_number(0);
    send_number(131071);
    send_number(2);
    send_number(1);
    send_number(1);
    send_number(2);

    // Small limit: a short ordered run with a stray number, ending above limit.
    write_limit(40);
    for (int unsigned n = 2; n <= 41; n++) begin
      if (n == 20) send_number(7);
      send_number(n);
    end

    // Widest register value, clamped inside; receiver holds off and the sender stalls.
    write_limit(131071);
    hold_request = 1;
    random_numbers(500);

    // Lower the limit mid-stream so unmarked numbers later read as prime.
    write_limit(next_number + 30);
    random_numbers(60);

    write_limit(65536);
    random_numbers(550);
    quiet = 1;
    random_numbers(200);

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (fail_count == 0) begin
      $display("linear_sieve_mobius_test: PASS");
    end else begin
      $display("linear_sieve_mobius_test: FAIL");
    end
    $finish;
  end

  // Covers the clearing pass after reset and the slowest walks over the primes.
  initial begin
    #50000000;
    $display("linear_sieve_mobius_test: FAIL");
    $finish;
  end
endmodule
`default_nettype wire
